@@ rtl/bsme_pkg.sv @@
// Shared types for the bounded set membership engine.
// Holds the command kinds, the controller state type, the control bundle and the result layout.
// No dependencies.
package bsme_pkg;

	// Width of the set_count field in a result transaction
	localparam int unsigned COUNT_W = 7;

	// Input command kinds
	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	// Controller states
	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_UPDATE = 1'b1
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;  // latch the input transaction and register the match vector
		logic commit;   // apply the update and load the result register
	} ctrl_cmd_t;

	// One result item
	typedef struct packed {
		logic               sets_equal;
		logic               all_found;
		logic               run_done;
		logic               dropped;
		logic [COUNT_W-1:0] set_count;
		logic               found;
	} result_t;

endpackage

@@ rtl/bounded_set_membership_engine.sv @@
// Top level of the bounded set membership engine.
// Joins the controller and the datapath and packs the stream ports.
// Depends on bsme_pkg, bsme_ctrl and bsme_datapath.

// Keeps a set of up to SET_DEPTH distinct keys, each compared on its low KEY_WIDTH
// bits. In the cycle an input transaction is accepted the key is compared against
// every cell at once and the match vector is registered; in the update state that
// follows, the set is updated and the result register is loaded. The update waits
// while a previous result is still held by a stalled output, and input is taken
// again once the result is loaded. No clearing pass follows reset; the set is
// empty at once. set_count carries the low 7 bits of the key count.
module bounded_set_membership_engine #(
	parameter int unsigned SET_DEPTH = 64,
	parameter int unsigned KEY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] key
	input  logic [1:0]  s_tuser,   // [1:0] kind
	input  logic        s_tlast,   // last element of a query run
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] found, [7:1] set_count, [8] dropped,
	                               // [9] all_found, [10] sets_equal, [15:11] zero
	output logic        m_tlast    // run_done
);

	bsme_pkg::ctrl_cmd_t cmd;
	bsme_pkg::result_t   result;

	bsme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	bsme_datapath #(
		.SET_DEPTH (SET_DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_kind (s_tuser),
		.in_key  (s_tdata),
		.in_last (s_tlast),
		.result  (result)
	);

	// Pack the result transaction
	assign m_tdata = {5'b0, result.sets_equal, result.all_found, result.dropped,
		result.set_count, result.found};
	assign m_tlast = result.run_done;

endmodule

@@ rtl/bsme_ctrl.sv @@
// Controller state machine of the bounded set membership engine.
// Sequences capture and commit and owns the valid flag of the result register.
// Depends on bsme_pkg.
module bsme_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output bsme_pkg::ctrl_cmd_t cmd
);

	bsme_pkg::state_t state_q;
	bsme_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bsme_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = bsme_pkg::ST_UPDATE;
			end
			bsme_pkg::ST_UPDATE: begin
				if (out_free) state_d = bsme_pkg::ST_IDLE;
			end
			default: state_d = bsme_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			bsme_pkg::ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			bsme_pkg::ST_UPDATE: begin
				cmd.commit = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsme_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid flag: set on commit, drop once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

@@ rtl/bsme_datapath.sv @@
// Datapath of the bounded set membership engine: key cells with valid bits,
// match vector register, counters, query run accumulators and result register.
// Depends on bsme_pkg.
module bsme_datapath #(
	parameter int unsigned SET_DEPTH = 64,
	parameter int unsigned KEY_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bsme_pkg::ctrl_cmd_t cmd,
	input  logic [1:0]          in_kind,
	input  logic [31:0]         in_key,
	input  logic                in_last,
	output bsme_pkg::result_t   result
);

	localparam int unsigned CW = $clog2(SET_DEPTH + 2);
	localparam logic [CW-1:0] LEN_MAX = CW'(SET_DEPTH + 1);

	logic [KEY_WIDTH-1:0] keys_q [SET_DEPTH];
	logic [SET_DEPTH-1:0] valid_q;
	logic [CW-1:0]        count_q;
	logic                 missing_q;
	logic [CW-1:0]        length_q;

	logic [KEY_WIDTH-1:0] key_in;
	logic [SET_DEPTH-1:0] match_s1;
	logic [KEY_WIDTH-1:0] key_s1;
	bsme_pkg::kind_t      kind_s1;
	logic                 last_s1;

	logic                 hit;
	logic                 full;
	logic [SET_DEPTH-1:0] free_vec;
	logic [SET_DEPTH-1:0] free_pick;

	logic [SET_DEPTH-1:0] valid_d;
	logic [CW-1:0]        count_d;
	logic                 missing_d;
	logic [CW-1:0]        length_d;
	logic [SET_DEPTH-1:0] write_en;
	bsme_pkg::result_t    result_d;
	bsme_pkg::result_t    result_q;

	assign key_in = KEY_WIDTH'(in_key);

	// Compare the incoming key against every cell and register the match vector
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int i = 0; i < SET_DEPTH; i++) begin
				match_s1[i] <= valid_q[i] && (keys_q[i] == key_in);
			end
			key_s1  <= key_in;
			kind_s1 <= bsme_pkg::kind_t'(in_kind);
			last_s1 <= in_last;
		end
	end

	// Hit and full flags, and the lowest free slot as a one-hot vector
	assign hit       = |match_s1;
	assign full      = &valid_q;
	assign free_vec  = ~valid_q;
	assign free_pick = free_vec & (~free_vec + SET_DEPTH'(1));

	// Update of set state and the result for this transaction
	always_comb begin
		valid_d              = valid_q;
		count_d              = count_q;
		missing_d            = missing_q;
		length_d             = length_q;
		write_en             = '0;
		result_d.found       = hit;
		result_d.dropped     = 1'b0;
		result_d.run_done    = 1'b0;
		result_d.all_found   = 1'b0;
		result_d.sets_equal  = 1'b0;
		case (kind_s1)
			bsme_pkg::KIND_INSERT: begin
				if (!hit) begin
					if (full) begin
						result_d.dropped = 1'b1;
					end else begin
						write_en = free_pick;
						valid_d  = valid_q | free_pick;
						count_d  = count_q + CW'(1);
					end
				end
			end
			bsme_pkg::KIND_REMOVE: begin
				if (hit) begin
					valid_d = valid_q & ~match_s1;
					count_d = count_q - CW'(1);
				end
			end
			bsme_pkg::KIND_QUERY: begin
				missing_d = missing_q | !hit;
				if (length_q != LEN_MAX) length_d = length_q + CW'(1);
				if (last_s1) begin
					result_d.run_done   = 1'b1;
					result_d.all_found  = !missing_d;
					result_d.sets_equal = !missing_d && (length_d == count_q);
					missing_d           = 1'b0;
					length_d            = '0;
				end
			end
			bsme_pkg::KIND_CLEAR: begin
				valid_d        = '0;
				count_d        = '0;
				missing_d      = 1'b0;
				length_d       = '0;
				result_d.found = 1'b0;
			end
			default: begin
				valid_d = valid_q;
			end
		endcase
		result_d.set_count = bsme_pkg::COUNT_W'(count_d);
	end

	// Key cells: write the key into the picked free slot
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < SET_DEPTH; i++) begin
				if (write_en[i]) keys_q[i] <= key_s1;
			end
		end
	end

	// Set state and run accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			count_q   <= '0;
			missing_q <= 1'b0;
			length_q  <= '0;
		end else if (cmd.commit) begin
			valid_q   <= valid_d;
			count_q   <= count_d;
			missing_q <= missing_d;
			length_q  <= length_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) result_q <= result_d;
	end

	assign result = result_q;

endmodule

@@ test/bounded_set_membership_engine_tb.sv @@
// Self-checking testbench for bounded_set_membership_engine.
// Drives a directed table, then random command sequences; checks each result against
// its table row or an in-bench set predictor. Depends on bsme_pkg and the top level.
module bounded_set_membership_engine_tb;

	localparam int SET_DEPTH  = 64;
	localparam int KEY_W      = 32;
	localparam int N_DIR      = 24;
	localparam int RAND_ITEMS = 500;

	// One row of the directed table; want is used only where typed is set
	typedef struct packed {
		bsme_pkg::kind_t   kind;
		logic [31:0]       key;
		logic              last;
		logic              typed;
		bsme_pkg::result_t want;
	} cmd_row_t;

	localparam bsme_pkg::result_t NO_WANT = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;   // [0] found, [7:1] set_count, [8] dropped,
	                        // [9] all_found, [10] sets_equal, [15:11] zero
	logic        m_tlast;   // run_done

	// Predicted set contents and query run accumulators
	logic [KEY_W-1:0] held_keys [SET_DEPTH];
	logic             held_valid [SET_DEPTH];
	int unsigned      held_total;
	logic             run_absent;
	int unsigned      run_len;

	bsme_pkg::result_t pending_results [$];
	cmd_row_t          dir_rows [N_DIR];
	int unsigned       send_idle_pct;
	int unsigned       recv_idle_pct;
	int unsigned       items_sent;
	int unsigned       runs_closed;
	int unsigned       inserts_refused;
	int unsigned       fills;
	int                error_count;

	bounded_set_membership_engine #(
		.SET_DEPTH(SET_DEPTH),
		.KEY_WIDTH(KEY_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always #4 clk = ~clk;

	// Stop a hung run
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Build a result for a table row
	function automatic bsme_pkg::result_t typed_result(bit f, int unsigned c, bit d,
	                                                   bit done, bit all, bit eq);
		bsme_pkg::result_t r;
		r.found      = f;
		r.set_count  = c[bsme_pkg::COUNT_W-1:0];
		r.dropped    = d;
		r.run_done   = done;
		r.all_found  = all;
		r.sets_equal = eq;
		return r;
	endfunction

	// Apply one command to the predicted set and return the result it causes
	function automatic bsme_pkg::result_t membership_result(bsme_pkg::kind_t kind,
	                                                        logic [31:0] key_in,
	                                                        logic last);
		bsme_pkg::result_t r;
		int                hit;
		int                slot;
		logic [KEY_W-1:0]  k;
		k   = key_in[KEY_W-1:0];
		hit = -1;
		slot = -1;
		for (int i = 0; i < SET_DEPTH; i++) begin
			if (hit < 0 && held_valid[i] && held_keys[i] == k)
				hit = i;
		end
		r = '0;
		r.found = (hit >= 0);
		case (kind)
			bsme_pkg::KIND_INSERT: begin
				if (hit < 0) begin
					for (int i = 0; i < SET_DEPTH; i++) begin
						if (slot < 0 && !held_valid[i])
							slot = i;
					end
					if (slot < 0) begin
						r.dropped = 1'b1;
						inserts_refused++;
					end else begin
						held_keys[slot]  = k;
						held_valid[slot] = 1'b1;
						held_total++;
					end
				end
			end
			bsme_pkg::KIND_REMOVE: begin
				if (hit >= 0) begin
					held_valid[hit] = 1'b0;
					if (held_total > 0)
						held_total--;
				end
			end
			bsme_pkg::KIND_QUERY: begin
				if (hit < 0)
					run_absent = 1'b1;
				// saturate so an overlong run never matches a count
				if (run_len < SET_DEPTH + 1)
					run_len++;
				if (last) begin
					r.run_done   = 1'b1;
					r.all_found  = !run_absent;
					r.sets_equal = !run_absent && (run_len == held_total);
					run_absent   = 1'b0;
					run_len      = 0;
					runs_closed++;
				end
			end
			default: begin
				for (int i = 0; i < SET_DEPTH; i++)
					held_valid[i] = 1'b0;
				held_total = 0;
				run_absent = 1'b0;
				run_len    = 0;
				r.found    = 1'b0;
			end
		endcase
		r.set_count = held_total[bsme_pkg::COUNT_W-1:0];
		return r;
	endfunction

	// Pick a key that the set holds now, or any key when it is empty
	function automatic logic [31:0] random_held_key();
		int idx [$];
		for (int i = 0; i < SET_DEPTH; i++) begin
			if (held_valid[i])
				idx.push_back(i);
		end
		if (idx.size() == 0)
			return $urandom;
		return held_keys[idx[$urandom_range(idx.size() - 1)]];
	endfunction

	// Offer one transaction, wait for the handshake, then queue its expected result
	task automatic send_item(bsme_pkg::kind_t kind, logic [31:0] key, logic last,
	                         logic typed, bsme_pkg::result_t want);
		bsme_pkg::result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= key;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = membership_result(kind, key, last);
		pending_results.push_back(typed ? want : r);
		items_sent++;
	endtask

	task automatic send(bsme_pkg::kind_t kind, logic [31:0] key, logic last);
		send_item(kind, key, last, 1'b0, NO_WANT);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Stall the output side at random
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		bsme_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result: expected none, got tdata %0h tlast %0d", m_tdata, m_tlast);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("found", want.found, m_tdata[0]);
				check_field("set_count", want.set_count, m_tdata[7:1]);
				check_field("dropped", want.dropped, m_tdata[8]);
				check_field("run_done", want.run_done, m_tlast);
				check_field("all_found", want.all_found, m_tdata[9]);
				check_field("sets_equal", want.sets_equal, m_tdata[10]);
				check_field("pad", 0, m_tdata[15:11]);
			end
		end
	end

	initial begin
		int unsigned sc;
		int unsigned len;
		int unsigned v;
		int unsigned n;
		int unsigned pick;
		int unsigned rand_done;
		logic [31:0] k;
		logic [31:0] tmp;
		logic [31:0] run_keys [$];
		logic [31:0] pool [16];

		for (int i = 0; i < SET_DEPTH; i++) begin
			held_keys[i]  = '0;
			held_valid[i] = 1'b0;
		end
		held_total      = 0;
		run_absent      = 1'b0;
		run_len         = 0;
		items_sent      = 0;
		runs_closed     = 0;
		inserts_refused = 0;
		fills           = 0;
		error_count     = 0;
		send_idle_pct   = 10;
		recv_idle_pct   = 75;
		for (int i = 0; i < 16; i++)
			pool[i] = $urandom;
		pool[0] = 32'h0000_0000;
		pool[1] = 32'hFFFF_FFFF;

		// Directed table: extremes, duplicates, last on non-query, runs with updates,
		// repeated elements, clear inside a run, commands on an empty set
		dir_rows[0]  = '{bsme_pkg::KIND_QUERY,  32'h0000_0000, 1'b1, 1'b1,
		                 typed_result(0, 0, 0, 1, 0, 0)};
		dir_rows[1]  = '{bsme_pkg::KIND_INSERT, 32'h0000_0000, 1'b0, 1'b1,
		                 typed_result(0, 1, 0, 0, 0, 0)};
		dir_rows[2]  = '{bsme_pkg::KIND_INSERT, 32'h0000_0000, 1'b0, 1'b1,
		                 typed_result(1, 1, 0, 0, 0, 0)};
		dir_rows[3]  = '{bsme_pkg::KIND_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b1,
		                 typed_result(0, 2, 0, 0, 0, 0)};
		dir_rows[4]  = '{bsme_pkg::KIND_INSERT, 32'h8000_0000, 1'b1, 1'b1,
		                 typed_result(0, 3, 0, 0, 0, 0)};
		dir_rows[5]  = '{bsme_pkg::KIND_QUERY,  32'hFFFF_FFFF, 1'b0, 1'b1,
		                 typed_result(1, 3, 0, 0, 0, 0)};
		dir_rows[6]  = '{bsme_pkg::KIND_QUERY,  32'h0000_0000, 1'b0, 1'b0, NO_WANT};
		dir_rows[7]  = '{bsme_pkg::KIND_INSERT, 32'h1234_5678, 1'b0, 1'b0, NO_WANT};
		dir_rows[8]  = '{bsme_pkg::KIND_QUERY,  32'h8000_0000, 1'b1, 1'b0, NO_WANT};
		dir_rows[9]  = '{bsme_pkg::KIND_QUERY,  32'h0000_0000, 1'b0, 1'b0, NO_WANT};
		dir_rows[10] = '{bsme_pkg::KIND_QUERY,  32'h0000_0000, 1'b0, 1'b0, NO_WANT};
		dir_rows[11] = '{bsme_pkg::KIND_QUERY,  32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT};
		dir_rows[12] = '{bsme_pkg::KIND_QUERY,  32'h8000_0000, 1'b1, 1'b0, NO_WANT};
		dir_rows[13] = '{bsme_pkg::KIND_REMOVE, 32'h1234_5678, 1'b0, 1'b0, NO_WANT};
		dir_rows[14] = '{bsme_pkg::KIND_REMOVE, 32'h1234_5678, 1'b0, 1'b0, NO_WANT};
		dir_rows[15] = '{bsme_pkg::KIND_REMOVE, 32'h0000_0001, 1'b1, 1'b0, NO_WANT};
		dir_rows[16] = '{bsme_pkg::KIND_QUERY,  32'h5555_5555, 1'b0, 1'b0, NO_WANT};
		dir_rows[17] = '{bsme_pkg::KIND_CLEAR,  32'h0000_0000, 1'b0, 1'b1,
		                 typed_result(0, 0, 0, 0, 0, 0)};
		dir_rows[18] = '{bsme_pkg::KIND_INSERT, 32'hAAAA_AAAA, 1'b0, 1'b1,
		                 typed_result(0, 1, 0, 0, 0, 0)};
		dir_rows[19] = '{bsme_pkg::KIND_QUERY,  32'hAAAA_AAAA, 1'b1, 1'b0, NO_WANT};
		dir_rows[20] = '{bsme_pkg::KIND_CLEAR,  32'h0000_0000, 1'b1, 1'b1,
		                 typed_result(0, 0, 0, 0, 0, 0)};
		dir_rows[21] = '{bsme_pkg::KIND_CLEAR,  32'hFFFF_FFFF, 1'b0, 1'b1,
		                 typed_result(0, 0, 0, 0, 0, 0)};
		dir_rows[22] = '{bsme_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b1,
		                 typed_result(0, 0, 0, 0, 0, 0)};
		dir_rows[23] = '{bsme_pkg::KIND_QUERY,  32'h7FFF_FFFF, 1'b1, 1'b1,
		                 typed_result(0, 0, 0, 1, 0, 0)};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIR; r++)
			send_item(dir_rows[r].kind, dir_rows[r].key, dir_rows[r].last,
			          dir_rows[r].typed, dir_rows[r].want);

		// Random command sequences, mostly well-formed query runs and updates
		rand_done = 0;
		while (rand_done < RAND_ITEMS) begin
			if (rand_done < RAND_ITEMS / 3) begin
				send_idle_pct = 10;
				recv_idle_pct = 75;
			end else if (rand_done < 2 * RAND_ITEMS / 3) begin
				send_idle_pct = 75;
				recv_idle_pct = 10;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			sc = $urandom_range(99);
			if ((sc < 3 || (fills == 0 && rand_done > RAND_ITEMS / 2)) && fills < 2) begin
				// fill the store, hit it while full, then run a full-length or overlong query
				fills++;
				while (held_total < SET_DEPTH)
					send(bsme_pkg::KIND_INSERT, $urandom, 1'b0);
				repeat ($urandom_range(1, 3))
					send(bsme_pkg::KIND_INSERT, $urandom, 1'($urandom_range(1)));
				send(bsme_pkg::KIND_INSERT, random_held_key(), 1'b0);
				len = $urandom_range(1) ? SET_DEPTH : $urandom_range(190, 200);
				for (int e = 0; e < len; e++)
					send(bsme_pkg::KIND_QUERY, held_keys[e % SET_DEPTH], e == len - 1);
				repeat ($urandom_range(1, 3))
					send(bsme_pkg::KIND_REMOVE, random_held_key(), 1'b0);
				repeat ($urandom_range(1, 3))
					send(bsme_pkg::KIND_INSERT, pool[$urandom_range(15)], 1'b0);
			end else if (sc < 33) begin
				// short query run over held keys, near misses and random keys
				len = $urandom_range(1, 6);
				for (int e = 0; e < len; e++) begin
					pick = $urandom_range(99);
					if (pick < 70)
						k = random_held_key();
					else if (pick < 85)
						k = random_held_key() ^ (32'h1 << $urandom_range(31));
					else
						k = $urandom;
					send(bsme_pkg::KIND_QUERY, k, e == len - 1);
				end
			end else if (sc < 45) begin
				// run over the whole set, exact or spoiled by one repeat or one stranger
				run_keys.delete();
				for (int i = 0; i < SET_DEPTH; i++) begin
					if (held_valid[i])
						run_keys.push_back(held_keys[i]);
				end
				if (run_keys.size() == 0)
					run_keys.push_back($urandom);
				v = $urandom_range(2);
				if (v == 1)
					run_keys.push_back(run_keys[$urandom_range(run_keys.size() - 1)]);
				else if (v == 2)
					run_keys[$urandom_range(run_keys.size() - 1)] = $urandom;
				for (int i = run_keys.size() - 1; i > 0; i--) begin
					n = $urandom_range(i);
					tmp = run_keys[i];
					run_keys[i] = run_keys[n];
					run_keys[n] = tmp;
				end
				for (int i = 0; i < run_keys.size(); i++)
					send(bsme_pkg::KIND_QUERY, run_keys[i], i == run_keys.size() - 1);
			end else if (sc < 70) begin
				// inserts from a small pool so that duplicates are common
				repeat ($urandom_range(1, 4))
					send(bsme_pkg::KIND_INSERT,
					     $urandom_range(1) ? pool[$urandom_range(15)] : $urandom, 1'b0);
			end else if (sc < 84) begin
				repeat ($urandom_range(1, 3)) begin
					pick = $urandom_range(99);
					if (pick < 60)
						k = random_held_key();
					else if (pick < 80)
						k = pool[$urandom_range(15)];
					else
						k = $urandom;
					send(bsme_pkg::KIND_REMOVE, k, 1'b0);
				end
			end else if (sc < 88) begin
				send(bsme_pkg::KIND_CLEAR, $urandom, 1'($urandom_range(1)));
			end else begin
				// noise: any kind with any key and last
				send(bsme_pkg::kind_t'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
			end
			rand_done = items_sent - N_DIR;
		end
		s_tvalid <= 1'b0;

		// Drain, then wait for any stray result
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d transactions (%0d from the table) over three idle patterns.",
		         items_sent, N_DIR);
		$display("Closed %0d query runs, refused %0d inserts, filled the store %0d times.",
		         runs_closed, inserts_refused, fills);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
